FILE: hdl/etcb_pkg.sv
// Shared types, constants and register codes for the encoder trim block.
`default_nettype none
package etcb_pkg;

  localparam logic [7:0]  TRIM_STEP       = 8'd2;
  localparam logic [7:0]  TRIM_HIGH_LIMIT = 8'd251;
  localparam logic [7:0]  TRIM_MAX        = 8'd255;
  localparam logic [7:0]  TRIM_LOW_LIMIT  = 8'd4;
  localparam logic [7:0]  TRIM_MIN        = 8'd0;
  localparam logic [15:0] COUNT_RESET     = 16'd32767;
  localparam logic [7:0]  CENTER_RESET    = 8'd127;
  localparam logic [15:0] DEBOUNCE_RESET  = 16'd50;
  localparam logic [15:0] LONG_RESET      = 16'd2000;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER   = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] encoder_count;
    logic        key_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [7:0] trim_value;
    logic       key_held;
    logic       long_press;
  } out_t;

  typedef struct packed {
    logic [7:0]  center_value;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] last_count;
    logic [7:0]  trim;
    logic        key_armed;
    logic        press_flag;
    logic        long_flag;
    logic [31:0] event_time;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    center_value:  CENTER_RESET,
    debounce_ms:   DEBOUNCE_RESET,
    long_press_ms: LONG_RESET
  };

  localparam state_t STATE_RESET = '{
    last_count: COUNT_RESET,
    trim:       CENTER_RESET,
    key_armed:  1'b0,
    press_flag: 1'b0,
    long_flag:  1'b0,
    event_time: 32'd0
  };

endpackage
`default_nettype wire

FILE: hdl/etcb_step.sv
// Next-state logic for one poll: encoder trim step and key debounce rules.
`default_nettype none
module etcb_step (
  input  etcb_pkg::state_t st,
  input  etcb_pkg::in_t    item,
  input  etcb_pkg::cfg_t   cfg,
  output etcb_pkg::state_t st_nxt
);
  import etcb_pkg::*;

  logic [7:0]  trim_cnt;
  logic [31:0] elapsed;
  logic        deb_ok;
  logic        long_ok;
  logic        armed;
  logic        released;

  // Counter first: rise steps up, fall steps down, both saturate.
  always_comb begin
    trim_cnt = st.trim;
    if (item.encoder_count > st.last_count) begin
      trim_cnt = (st.trim > TRIM_HIGH_LIMIT) ? TRIM_MAX : st.trim + TRIM_STEP;
    end else if (item.encoder_count < st.last_count) begin
      trim_cnt = (st.trim < TRIM_LOW_LIMIT) ? TRIM_MIN : st.trim - TRIM_STEP;
    end
  end

  assign released = item.key_level;
  assign armed    = st.key_armed | released;
  assign elapsed  = item.now_ms - st.event_time;
  assign deb_ok   = elapsed > {16'd0, cfg.debounce_ms};
  assign long_ok  = elapsed > {16'd0, cfg.long_press_ms};

  // Key rules: first match wins.
  always_comb begin
    st_nxt            = st;
    st_nxt.last_count = item.encoder_count;
    st_nxt.trim       = trim_cnt;
    st_nxt.key_armed  = armed;
    if (armed) begin
      if (!released && !st.press_flag && deb_ok) begin
        st_nxt.press_flag = 1'b1;
        st_nxt.long_flag  = 1'b0;
        st_nxt.event_time = item.now_ms;
      end else if (!released && !st.long_flag && long_ok) begin
        st_nxt.long_flag = 1'b1;
      end else if (released && st.press_flag && deb_ok) begin
        st_nxt.press_flag = 1'b0;
        st_nxt.event_time = item.now_ms;
        if (!st.long_flag) begin
          st_nxt.trim = cfg.center_value;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/encoder_trim_with_center_button.sv
// Top level: poll input register, single-pass update, result register, config registers.
// The result register loads from the input stage when its poll advances; a stalled output holds it back.
// Throughput: one poll per cycle while the output is not stalled; each poll sees the state left by the one before.
// A stalled result holds in the output register while one more poll waits in the input stage.
// Reset (synchronous, rst_n low): state and config return to their defaults, no beats pending.
`default_nettype none
module encoder_trim_with_center_button (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  etcb_pkg::in_t        in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output etcb_pkg::out_t       out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [15:0]           cfg_data
);
  import etcb_pkg::*;

  logic   s1_valid_r;
  in_t    s1_data_r;
  logic   out_valid_r;
  out_t   out_data_r;
  state_t st_r;
  state_t st_nxt;
  cfg_t   cfg_r;
  logic   s1_adv;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  etcb_step u_step (
    .st     (st_r),
    .item   (s1_data_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
      cfg_r       <= CFG_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CENTER:   cfg_r.center_value  <= cfg_data[7:0];
          CFG_DEBOUNCE: cfg_r.debounce_ms   <= cfg_data;
          CFG_LONG:     cfg_r.long_press_ms <= cfg_data;
          default:      cfg_r <= cfg_r;
        endcase
      end
    end
  end

  // Payload: load on beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r.trim_value <= st_nxt.trim;
      out_data_r.key_held   <= st_nxt.press_flag;
      out_data_r.long_press <= st_nxt.long_flag;
    end
  end

  a_flags_need_arm: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.key_armed |-> (!st_r.press_flag && !st_r.long_flag))
    else $error("key flag set before key armed");

  a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.trim_value == st_r.trim &&
                     out_data_r.key_held == st_r.press_flag &&
                     out_data_r.long_press == st_r.long_flag))
    else $error("result register out of step with state");

  a_press_on_low_key: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.press_flag) |-> $past(s1_valid_r && !s1_data_r.key_level))
    else $error("press accepted without a low key poll");

  a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted poll beat lost");

endmodule
`default_nettype wire
